// ===== hw/rtl/bafilt_pkg.sv =====
// Package for the bearer admission filter: operation and cause codes,
// sequencer states, the control group broadcast to the list cells, and limits.
// No dependencies.
package bafilt_pkg;

	localparam int ID_W         = 8;
	localparam int CAUSE_W      = 3;
	localparam int RATE_W       = 40;
	localparam int FAIL_W       = CAUSE_W + ID_W;
	localparam int LIST_DEPTH_DEF = 16;

	localparam logic [7:0] ID_MIN       = 8'd1;
	localparam logic [7:0] ID_MAX       = 8'd15;
	localparam logic [7:0] QCI_MIN      = 8'd1;
	localparam logic [7:0] QCI_MAX      = 8'd9;
	localparam logic [7:0] ARP_MIN      = 8'd1;
	localparam logic [7:0] ARP_MAX      = 8'd15;
	localparam logic [7:0] QCI_GBR_MAX  = 8'd4;

	typedef enum logic [1:0] {
		OP_FILTER    = 2'd0,
		OP_READ_ADM  = 2'd1,
		OP_READ_FAIL = 2'd2,
		OP_CLEAR     = 2'd3
	} op_t;

	typedef enum logic [CAUSE_W-1:0] {
		CAUSE_OK      = 3'd0,
		CAUSE_BAD_ID  = 3'd1,
		CAUSE_DUP     = 3'd2,
		CAUSE_BAD_QCI = 3'd3,
		CAUSE_BAD_ARP = 3'd4,
		CAUSE_BAD_GBR = 3'd5
	} cause_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_UPDATE
	} state_t;

	// Control broadcast to every cell of one list.
	typedef struct packed {
		logic            search;  // capture the key compare into the hit flag
		logic            remove;  // close the gap behind the hit entry
		logic            append;  // write the cell that sits at the count
		logic [ID_W-1:0] key;     // bearer id being looked up
		logic [7:0]      idx;     // list position being read
	} cell_ctl_t;

endpackage

// ===== hw/rtl/bafilt_cell.sv =====
// One list position of the bearer admission filter: holds one entry,
// compares it with the key, and passes read data and the shift flag on.
// Depends on bafilt_pkg.
module bafilt_cell #(
	parameter int INDEX  = 0,
	parameter int DATA_W = 8,
	parameter int CNT_W  = 5
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  bafilt_pkg::cell_ctl_t ctl,
	input  logic [CNT_W-1:0]      count,
	input  logic [DATA_W-1:0]     wr_data,
	input  logic [DATA_W-1:0]     nbr_data,
	output logic [DATA_W-1:0]     data,
	input  logic                  shift_in,
	output logic                  shift_out,
	input  logic [DATA_W-1:0]     rd_in,
	output logic [DATA_W-1:0]     rd_out
);
	import bafilt_pkg::*;

	logic [DATA_W-1:0] data_q;
	logic              hit_q;
	logic              live;
	logic              eq;
	logic              sel;

	// Only positions below the count hold entries.
	assign live = CNT_W'(INDEX) < count;
	assign eq   = live && (data_q[ID_W-1:0] == ctl.key);
	assign sel  = live && (ctl.idx == 8'(INDEX));

	// A hit here or in any lower cell means this cell takes its upper neighbor.
	assign shift_out = shift_in | hit_q;
	assign rd_out    = rd_in | (sel ? data_q : '0);
	assign data      = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
		end else if (ctl.search) begin
			hit_q <= eq;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.remove && shift_out) begin
			data_q <= nbr_data;
		end else if (ctl.append && (CNT_W'(INDEX) == count)) begin
			data_q <= wr_data;
		end
	end

endmodule

// ===== hw/rtl/bearer_admission_filter.sv =====
// Bearer admission filter: a request accepted in the idle step is searched through the
// cell rows, then updated, and its result is registered valid on the master side.
// A new request is taken only after the accept, search and update steps of the last one
// over the two rows of list cells; a held result stalls only the update step.
// Reset clears both list counts, the sequencer and the output valid flag; the
// list contents are not cleared, since entries above the count are never read.
module bearer_admission_filter #(
	parameter int LIST_DEPTH = bafilt_pkg::LIST_DEPTH_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// bearer_id[7:0], qci[15:8], arp_level[23:16], gbr_present[24],
	// dl_guaranteed[64:25], dl_maximum[104:65], ul_guaranteed[144:105],
	// ul_maximum[184:145], entry_index[192:185], zero fill[199:193]
	input  logic [199:0] s_axis_tdata,
	// operation[1:0]
	input  logic [1:0]   s_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// cause[2:0], recorded[3], entry_id[11:4], entry_cause[14:12],
	// admitted_count[19:15], failed_count[24:20], zero fill[31:25]
	output logic [31:0]  m_axis_tdata
);
	import bafilt_pkg::*;

	localparam int CNT_W = $clog2(LIST_DEPTH + 1);

	state_t state_q, state_d;

	// Request captured on acceptance. The two rate checks are made right at
	// the input so only one bit per request is kept.
	op_t             op_q;
	logic [ID_W-1:0] id_q;
	logic [7:0]      qci_q;
	logic [7:0]      arp_q;
	logic            gbr_q;
	logic            rate_ok_q;
	logic [7:0]      idx_q;

	logic [CNT_W-1:0] adm_cnt_q, fail_cnt_q;
	logic [CNT_W-1:0] adm_cnt_d, fail_cnt_d;

	// Read data from the search pass, registered before it is used.
	logic [ID_W-1:0]   adm_rd_q;
	logic [FAIL_W-1:0] fail_rd_q;

	// Output register that parts the result from the next request.
	logic               m_valid_q;
	cause_t             out_cause_q;
	logic               out_rec_q;
	logic [ID_W-1:0]    out_eid_q;
	logic [CAUSE_W-1:0] out_ecause_q;
	logic [4:0]         out_adm_q, out_fail_q;

	cell_ctl_t adm_ctl, fail_ctl;
	logic      accept, advance;
	cause_t    cause;
	logic      adm_found, fail_found;
	logic      recorded;
	logic [ID_W-1:0]    eid;
	logic [CAUSE_W-1:0] ecause;

	// Cell rows. The shift flag and read data ripple from position 0 upward;
	// the top cell takes zeros when the list closes a gap.
	logic [ID_W-1:0]   adm_data  [LIST_DEPTH];
	logic [ID_W-1:0]   adm_rd    [LIST_DEPTH+1];
	logic              adm_sh    [LIST_DEPTH+1];
	logic [FAIL_W-1:0] fail_data [LIST_DEPTH];
	logic [FAIL_W-1:0] fail_rd   [LIST_DEPTH+1];
	logic              fail_sh   [LIST_DEPTH+1];

	assign adm_rd[0]  = '0;
	assign adm_sh[0]  = 1'b0;
	assign fail_rd[0] = '0;
	assign fail_sh[0] = 1'b0;

	for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cells
		logic [ID_W-1:0]   adm_nbr;
		logic [FAIL_W-1:0] fail_nbr;

		if (i == LIST_DEPTH - 1) begin : g_top
			assign adm_nbr  = '0;
			assign fail_nbr = '0;
		end else begin : g_mid
			assign adm_nbr  = adm_data[i+1];
			assign fail_nbr = fail_data[i+1];
		end

		bafilt_cell #(
			.INDEX  (i),
			.DATA_W (ID_W),
			.CNT_W  (CNT_W)
		) u_adm (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (adm_ctl),
			.count     (adm_cnt_q),
			.wr_data   (id_q),
			.nbr_data  (adm_nbr),
			.data      (adm_data[i]),
			.shift_in  (adm_sh[i]),
			.shift_out (adm_sh[i+1]),
			.rd_in     (adm_rd[i]),
			.rd_out    (adm_rd[i+1])
		);

		bafilt_cell #(
			.INDEX  (i),
			.DATA_W (FAIL_W),
			.CNT_W  (CNT_W)
		) u_fail (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (fail_ctl),
			.count     (fail_cnt_q),
			.wr_data   ({cause, id_q}),
			.nbr_data  (fail_nbr),
			.data      (fail_data[i]),
			.shift_in  (fail_sh[i]),
			.shift_out (fail_sh[i+1]),
			.rd_in     (fail_rd[i]),
			.rd_out    (fail_rd[i+1])
		);
	end

	// The end of each shift chain tells whether any cell hit in the search pass.
	assign adm_found  = adm_sh[LIST_DEPTH];
	assign fail_found = fail_sh[LIST_DEPTH];

	assign accept  = s_axis_tvalid && s_axis_tready;
	assign advance = !m_valid_q || m_axis_tready;

	// Checks in the order the request is judged; the first failure wins.
	always_comb begin
		if (id_q < ID_MIN || id_q > ID_MAX) begin
			cause = CAUSE_BAD_ID;
		end else if (adm_found || fail_found) begin
			cause = CAUSE_DUP;
		end else if (qci_q < QCI_MIN || qci_q > QCI_MAX) begin
			cause = CAUSE_BAD_QCI;
		end else if (arp_q < ARP_MIN || arp_q > ARP_MAX) begin
			cause = CAUSE_BAD_ARP;
		end else if (qci_q <= QCI_GBR_MAX && gbr_q && !rate_ok_q) begin
			cause = CAUSE_BAD_GBR;
		end else begin
			cause = CAUSE_OK;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_axis_tvalid) begin
					state_d = ST_SEARCH;
				end
			end
			ST_SEARCH: begin
				state_d = ST_UPDATE;
			end
			ST_UPDATE: begin
				if (advance) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Outputs of the sequencer: cell controls, list counts and the result.
	always_comb begin
		s_axis_tready = 1'b0;
		adm_ctl       = '{search: 1'b0, remove: 1'b0, append: 1'b0, key: id_q, idx: idx_q};
		fail_ctl      = '{search: 1'b0, remove: 1'b0, append: 1'b0, key: id_q, idx: idx_q};
		adm_cnt_d     = adm_cnt_q;
		fail_cnt_d    = fail_cnt_q;
		recorded      = 1'b0;
		eid           = '0;
		ecause        = '0;
		case (state_q)
			ST_IDLE: begin
				s_axis_tready = 1'b1;
			end
			ST_SEARCH: begin
				adm_ctl.search  = 1'b1;
				fail_ctl.search = 1'b1;
			end
			ST_UPDATE: begin
				case (op_q)
					OP_FILTER: begin
						if (cause == CAUSE_OK) begin
							if (adm_cnt_q < CNT_W'(LIST_DEPTH)) begin
								adm_ctl.append = advance;
								adm_cnt_d      = adm_cnt_q + CNT_W'(1);
								recorded       = 1'b1;
							end
						end else begin
							// A duplicate leaves the admitted list before the
							// failed list is tried.
							if (cause == CAUSE_DUP && adm_found) begin
								adm_ctl.remove = advance;
								adm_cnt_d      = adm_cnt_q - CNT_W'(1);
							end
							if (fail_cnt_q < CNT_W'(LIST_DEPTH) && !fail_found) begin
								fail_ctl.append = advance;
								fail_cnt_d      = fail_cnt_q + CNT_W'(1);
								recorded        = 1'b1;
							end
						end
					end
					OP_READ_ADM: begin
						eid = adm_rd_q;
					end
					OP_READ_FAIL: begin
						eid    = fail_rd_q[ID_W-1:0];
						ecause = fail_rd_q[FAIL_W-1:ID_W];
					end
					OP_CLEAR: begin
						adm_cnt_d  = '0;
						fail_cnt_d = '0;
					end
					default: begin
						eid = '0;
					end
				endcase
			end
			default: begin
				s_axis_tready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			adm_cnt_q  <= '0;
			fail_cnt_q <= '0;
			m_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_UPDATE && advance) begin
				adm_cnt_q  <= adm_cnt_d;
				fail_cnt_q <= fail_cnt_d;
				m_valid_q  <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q      <= op_t'(s_axis_tuser);
			id_q      <= s_axis_tdata[7:0];
			qci_q     <= s_axis_tdata[15:8];
			arp_q     <= s_axis_tdata[23:16];
			gbr_q     <= s_axis_tdata[24];
			rate_ok_q <= (s_axis_tdata[64:25] <= s_axis_tdata[104:65]) &&
			             (s_axis_tdata[144:105] <= s_axis_tdata[184:145]);
			idx_q     <= s_axis_tdata[192:185];
		end
		if (state_q == ST_SEARCH) begin
			adm_rd_q  <= adm_rd[LIST_DEPTH];
			fail_rd_q <= fail_rd[LIST_DEPTH];
		end
		if (state_q == ST_UPDATE && advance) begin
			// Filter requests report a cause; all other operations report OK.
			out_cause_q  <= (op_q == OP_FILTER) ? cause : CAUSE_OK;
			out_rec_q    <= recorded;
			out_eid_q    <= eid;
			out_ecause_q <= ecause;
			out_adm_q    <= 5'(adm_cnt_d);
			out_fail_q   <= 5'(fail_cnt_d);
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {7'd0, out_fail_q, out_adm_q, out_ecause_q, out_eid_q,
	                        out_rec_q, out_cause_q};

	// An id is never held in both lists at once.
	a_lists_disjoint: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_UPDATE) |-> !(adm_found && fail_found))
		else $error("bearer id found in both lists");

	// Counts never pass the list depth.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(adm_cnt_q <= CNT_W'(LIST_DEPTH)) && (fail_cnt_q <= CNT_W'(LIST_DEPTH)))
		else $error("list count beyond depth");

	// The failed list only shrinks on a clear.
	a_fail_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_UPDATE && advance && op_q != OP_CLEAR) |=>
		(fail_cnt_q >= $past(fail_cnt_q)))
		else $error("failed list shrank without a clear");

	// The admitted list never appends and closes a gap in the same cycle.
	a_adm_one_write: assert property (@(posedge clk) disable iff (!arst_n)
		!(adm_ctl.append && adm_ctl.remove))
		else $error("admitted list append and remove together");

endmodule

// ===== sim/bearer_admission_filter_tb.sv =====
// Self-checking testbench for bearer_admission_filter: directed screening cases,
// a list capacity run and randomized request traffic under varying back-pressure.
// Depends on bafilt_pkg and the bearer_admission_filter RTL.
`timescale 1ns / 1ps

module bearer_admission_filter_tb;
	import bafilt_pkg::*;

	localparam int DEPTH = LIST_DEPTH_DEF;
	localparam int CYCLE_LIMIT = 200000;
	localparam logic [RATE_W-1:0] RATE_MAX = {RATE_W{1'b1}};

	// One setup, read or clear request as the block sees it on the slave side.
	typedef struct packed {
		op_t               op;
		logic [7:0]        bearer_id;
		logic [7:0]        qci;
		logic [7:0]        arp_level;
		logic              gbr_present;
		logic [RATE_W-1:0] dl_guaranteed;
		logic [RATE_W-1:0] dl_maximum;
		logic [RATE_W-1:0] ul_guaranteed;
		logic [RATE_W-1:0] ul_maximum;
		logic [7:0]        entry_index;
	} setup_req_t;

	// One verdict as it comes back on the master side.
	typedef struct packed {
		cause_t     cause;
		logic       recorded;
		logic [7:0] entry_id;
		logic [2:0] entry_cause;
		logic [4:0] admitted_count;
		logic [4:0] failed_count;
	} verdict_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [199:0] s_axis_tdata = '0;
	logic [1:0]   s_axis_tuser = '0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [31:0]  m_axis_tdata;

	// Shadow copy of the two bearer lists, updated in request order.
	logic [7:0] admitted_ids [DEPTH];
	int         admitted_total = 0;
	logic [7:0] rejected_ids [DEPTH];
	cause_t     rejected_causes [DEPTH];
	int         rejected_total = 0;

	verdict_t expected_verdicts [$];

	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	int mismatches = 0;
	int verdicts_checked = 0;
	int cycle_count = 0;
	int filter_requests = 0;
	int read_requests = 0;
	int clear_requests = 0;
	int unrecorded_filters = 0;
	int peak_admitted = 0;
	int peak_rejected = 0;
	int cause_hits [6] = '{default: 0};

	bearer_admission_filter #(
		.LIST_DEPTH(DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	always #5 clk = ~clk;

	// Works out the verdict of one accepted request and applies its effect on the
	// shadow lists. The checks run in the same order as in the block: id range,
	// duplicate in either list, QCI, ARP, then the GBR rate ordering for QCI 1..4.
	function automatic verdict_t admit_request(input setup_req_t r);
		verdict_t v;
		bit       in_admitted;
		bit       in_rejected;
		int       hit_pos;
		v = '0;
		v.cause = CAUSE_OK;
		in_admitted = 1'b0;
		in_rejected = 1'b0;
		hit_pos = 0;
		case (r.op)
			OP_FILTER: begin
				for (int i = 0; i < admitted_total; i++) begin
					if (!in_admitted && admitted_ids[i] == r.bearer_id) begin
						in_admitted = 1'b1;
						hit_pos = i;
					end
				end
				for (int i = 0; i < rejected_total; i++) begin
					if (rejected_ids[i] == r.bearer_id)
						in_rejected = 1'b1;
				end
				if (r.bearer_id < ID_MIN || r.bearer_id > ID_MAX)
					v.cause = CAUSE_BAD_ID;
				else if (in_admitted || in_rejected)
					v.cause = CAUSE_DUP;
				else if (r.qci < QCI_MIN || r.qci > QCI_MAX)
					v.cause = CAUSE_BAD_QCI;
				else if (r.arp_level < ARP_MIN || r.arp_level > ARP_MAX)
					v.cause = CAUSE_BAD_ARP;
				else if (r.qci <= QCI_GBR_MAX && r.gbr_present &&
						(r.dl_guaranteed > r.dl_maximum || r.ul_guaranteed > r.ul_maximum))
					v.cause = CAUSE_BAD_GBR;

				if (v.cause == CAUSE_OK) begin
					if (admitted_total < DEPTH) begin
						admitted_ids[admitted_total] = r.bearer_id;
						admitted_total++;
						v.recorded = 1'b1;
					end
				end else begin
					// A duplicate leaves the admitted list, and the entries behind it
					// move down one place.
					if (v.cause == CAUSE_DUP && in_admitted) begin
						for (int i = hit_pos; i + 1 < admitted_total; i++)
							admitted_ids[i] = admitted_ids[i + 1];
						admitted_total--;
					end
					// An id that already failed once is never written twice.
					if (rejected_total < DEPTH && !in_rejected) begin
						rejected_ids[rejected_total] = r.bearer_id;
						rejected_causes[rejected_total] = v.cause;
						rejected_total++;
						v.recorded = 1'b1;
					end
				end
			end
			OP_READ_ADM: begin
				if (r.entry_index < admitted_total)
					v.entry_id = admitted_ids[r.entry_index];
			end
			OP_READ_FAIL: begin
				if (r.entry_index < rejected_total) begin
					v.entry_id = rejected_ids[r.entry_index];
					v.entry_cause = rejected_causes[r.entry_index];
				end
			end
			default: begin
				admitted_total = 0;
				rejected_total = 0;
			end
		endcase
		v.admitted_count = 5'(admitted_total);
		v.failed_count = 5'(rejected_total);
		return v;
	endfunction

	function automatic logic [RATE_W-1:0] random_rate();
		return RATE_W'({$urandom, $urandom});
	endfunction

	// A request with a given id and random QoS content that passes the QCI, ARP and GBR rate checks.
	function automatic setup_req_t valid_request(input logic [7:0] id);
		setup_req_t r;
		logic [RATE_W-1:0] swap;
		r.op = OP_FILTER;
		r.bearer_id = id;
		r.qci = 8'($urandom_range(QCI_MAX, QCI_MIN));
		r.arp_level = 8'($urandom_range(ARP_MAX, ARP_MIN));
		r.gbr_present = 1'($urandom);
		r.dl_guaranteed = random_rate();
		r.dl_maximum = random_rate();
		r.ul_guaranteed = random_rate();
		r.ul_maximum = random_rate();
		r.entry_index = 8'($urandom);
		if (r.dl_guaranteed > r.dl_maximum) begin
			swap = r.dl_guaranteed;
			r.dl_guaranteed = r.dl_maximum;
			r.dl_maximum = swap;
		end
		if (r.ul_guaranteed > r.ul_maximum) begin
			swap = r.ul_guaranteed;
			r.ul_guaranteed = r.ul_maximum;
			r.ul_maximum = swap;
		end
		return r;
	endfunction

	function automatic setup_req_t filter_fields(input logic [7:0] id, input logic [7:0] qci,
			input logic [7:0] arp, input logic gbr,
			input logic [RATE_W-1:0] dlg, input logic [RATE_W-1:0] dlm,
			input logic [RATE_W-1:0] ulg, input logic [RATE_W-1:0] ulm);
		setup_req_t r;
		r = '{OP_FILTER, id, qci, arp, gbr, dlg, dlm, ulg, ulm, 8'($urandom)};
		return r;
	endfunction

	// Read and clear requests carry random filler in the fields they do not use.
	function automatic setup_req_t list_op(input op_t op, input logic [7:0] idx);
		setup_req_t r;
		r = '{op, 8'($urandom), 8'($urandom), 8'($urandom), 1'($urandom),
			random_rate(), random_rate(), random_rate(), random_rate(), idx};
		return r;
	endfunction

	// Presents one request after a random gap and waits for the slave handshake.
	// Valid stays high after the handshake, so back-to-back requests never drop it.
	task automatic send_request(input setup_req_t r);
		int gap;
		verdict_t v;
		gap = 0;
		while ($urandom_range(99) < tx_idle_pct)
			gap++;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= r.op;
		s_axis_tdata <= {7'd0, r.entry_index, r.ul_maximum, r.ul_guaranteed, r.dl_maximum,
			r.dl_guaranteed, r.gbr_present, r.arp_level, r.qci, r.bearer_id};
		do @(posedge clk); while (!s_axis_tready);
		v = admit_request(r);
		expected_verdicts.push_back(v);
		case (r.op)
			OP_FILTER: begin
				filter_requests++;
				cause_hits[v.cause]++;
				if (!v.recorded)
					unrecorded_filters++;
			end
			OP_CLEAR: clear_requests++;
			default: read_requests++;
		endcase
		if (admitted_total > peak_admitted)
			peak_admitted = admitted_total;
		if (rejected_total > peak_rejected)
			peak_rejected = rejected_total;
	endtask

	// Stops sending until every outstanding verdict has come back.
	task automatic hold_until_drained();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (expected_verdicts.size() != 0);
	endtask

	// Field extremes, every operation and each failure cause, including the
	// duplicate that evicts an admitted id and an already-failed id.
	task automatic test_directed_screening();
		send_request(list_op(OP_READ_ADM, 8'd0));
		send_request(list_op(OP_READ_FAIL, 8'd255));
		// Guaranteed equal to maximum passes; zero rates pass too.
		send_request(filter_fields(8'd1, 8'd1, 8'd1, 1'b1, RATE_MAX, RATE_MAX, '0, '0));
		// QCI 9 is non-GBR, so inverted rates are not looked at.
		send_request(filter_fields(8'd15, 8'd9, 8'd15, 1'b1, RATE_MAX, '0, RATE_MAX, '0));
		send_request(filter_fields(8'd0, 8'd5, 8'd5, 1'b0, '0, '0, '0, '0));
		send_request(filter_fields(8'd16, 8'd5, 8'd5, 1'b0, '0, '0, '0, '0));
		send_request(filter_fields(8'd255, 8'd255, 8'd255, 1'b1,
			RATE_MAX, RATE_MAX, RATE_MAX, RATE_MAX));
		// An invalid id that has already failed is reported but not stored again.
		send_request(filter_fields(8'd0, 8'd0, 8'd0, 1'b0, '0, '0, '0, '0));
		send_request(filter_fields(8'd2, 8'd0, 8'd5, 1'b0, '0, '0, '0, '0));
		send_request(filter_fields(8'd3, 8'd10, 8'd5, 1'b0, '0, '0, '0, '0));
		send_request(filter_fields(8'd4, 8'd5, 8'd0, 1'b0, '0, '0, '0, '0));
		send_request(filter_fields(8'd5, 8'd5, 8'd16, 1'b0, '0, '0, '0, '0));
		send_request(filter_fields(8'd6, 8'd4, 8'd8, 1'b1, 40'd1001, 40'd1000, '0, '0));
		send_request(filter_fields(8'd7, 8'd4, 8'd8, 1'b1, '0, RATE_MAX, RATE_MAX, 40'd7));
		// Without GBR information the rate ordering is ignored even for QCI 4.
		send_request(filter_fields(8'd8, 8'd4, 8'd8, 1'b0, RATE_MAX, '0, RATE_MAX, '0));
		// Duplicate of the first admitted id: it leaves the admitted list.
		send_request(filter_fields(8'd1, 8'd1, 8'd1, 1'b0, '0, '0, '0, '0));
		// Duplicate of a failed id: cause reported, nothing written.
		send_request(valid_request(8'd2));
		for (int i = 0; i < 3; i++)
			send_request(list_op(OP_READ_ADM, 8'(i)));
		send_request(list_op(OP_READ_FAIL, 8'd0));
		send_request(list_op(OP_READ_FAIL, 8'(rejected_total - 1)));
		send_request(list_op(OP_READ_FAIL, 8'(rejected_total)));
		send_request(list_op(OP_CLEAR, 8'd0));
		send_request(list_op(OP_READ_ADM, 8'd0));
	endtask

	// Admits all fifteen legal ids in random order, then overfills the failed list
	// with distinct bad ids so that the full-list case is hit.
	task automatic test_list_capacity();
		logic [7:0] order [15];
		logic [7:0] t;
		int j;
		for (int i = 0; i < 15; i++)
			order[i] = 8'(i + 1);
		for (int i = 14; i > 0; i--) begin
			j = $urandom_range(i);
			t = order[i];
			order[i] = order[j];
			order[j] = t;
		end
		send_request(list_op(OP_CLEAR, 8'($urandom)));
		for (int i = 0; i < 15; i++)
			send_request(valid_request(order[i]));
		send_request(list_op(OP_READ_ADM, 8'd14));
		send_request(list_op(OP_READ_ADM, 8'd15));
		for (int k = 0; k <= DEPTH; k++)
			send_request(filter_fields(8'(16 + k * 14 + $urandom_range(13)), 8'($urandom),
				8'($urandom), 1'($urandom), random_rate(), random_rate(), random_rate(),
				random_rate()));
		// With the failed list full, a duplicate still evicts but is not stored.
		send_request(valid_request(order[$urandom_range(14)]));
		send_request(list_op(OP_READ_FAIL, 8'(DEPTH - 1)));
		send_request(list_op(OP_READ_FAIL, 8'(DEPTH)));
		send_request(list_op(OP_CLEAR, 8'($urandom)));
	endtask

	// Mostly well-formed setup requests with random QoS content, mixed with reads,
	// occasional clears and requests that break one check or are pure noise.
	task automatic test_random_traffic(input int count, input int tx_pct, input int rx_pct);
		setup_req_t r;
		int pick;
		tx_idle_pct = tx_pct;
		rx_idle_pct = rx_pct;
		for (int n = 0; n < count; n++) begin
			if (n == count / 2)
				hold_until_drained();
			pick = $urandom_range(99);
			if (pick < 3) begin
				r = list_op(OP_CLEAR, 8'($urandom));
			end else if (pick < 19) begin
				r = list_op(pick < 11 ? OP_READ_ADM : OP_READ_FAIL,
					$urandom_range(3) != 0 ? 8'($urandom_range(DEPTH)) : 8'($urandom));
			end else begin
				r = valid_request(8'($urandom_range(ID_MAX, ID_MIN)));
				if ($urandom_range(99) < 25) begin
					case ($urandom_range(4))
						0: r.bearer_id = 8'($urandom);
						1: r.qci = 8'($urandom);
						2: r.arp_level = 8'($urandom);
						3: begin
							r.qci = 8'($urandom_range(QCI_GBR_MAX, QCI_MIN));
							r.gbr_present = 1'b1;
							r.dl_guaranteed = random_rate();
							r.ul_guaranteed = random_rate();
						end
						default: r = filter_fields(8'($urandom), 8'($urandom),
							8'($urandom), 1'($urandom), random_rate(), random_rate(),
							random_rate(), random_rate());
					endcase
				end
			end
			send_request(r);
		end
	endtask

	// Result side: checks each accepted verdict against the oldest expectation and
	// then picks the ready level for the next cycle.
	always @(posedge clk) begin : verdict_check
		verdict_t got;
		verdict_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.cause = cause_t'(m_axis_tdata[2:0]);
			got.recorded = m_axis_tdata[3];
			got.entry_id = m_axis_tdata[11:4];
			got.entry_cause = m_axis_tdata[14:12];
			got.admitted_count = m_axis_tdata[19:15];
			got.failed_count = m_axis_tdata[24:20];
			verdicts_checked++;
			if (expected_verdicts.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: verdict with no request outstanding: data %h",
						$realtime, m_axis_tdata);
			end else begin
				want = expected_verdicts.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: verdict %0d differs: cause %0d/%0d recorded %0d/%0d ",
							$realtime, verdicts_checked, want.cause, got.cause,
							want.recorded, got.recorded,
							"entry_id %0d/%0d entry_cause %0d/%0d admitted %0d/%0d ",
							want.entry_id, got.entry_id, want.entry_cause, got.entry_cause,
							want.admitted_count, got.admitted_count,
							"failed %0d/%0d (expected/actual)",
							want.failed_count, got.failed_count);
				end
			end
		end
		m_axis_tready <= arst_n && ($urandom_range(99) >= rx_idle_pct);
	end

	// Watchdog: a hung handshake ends the run as a failure.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles with %0d verdicts outstanding",
				cycle_count, expected_verdicts.size());
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		tx_idle_pct = 31;
		rx_idle_pct = 59;
		test_directed_screening();
		test_list_capacity();
		test_random_traffic(420, 31, 59);
		test_random_traffic(420, 59, 31);
		test_random_traffic(420, 0, 0);
		s_axis_tvalid <= 1'b0;
		while (expected_verdicts.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		$display("Ran %0d setup requests, %0d list reads and %0d clears; %0d verdicts checked.",
			filter_requests, read_requests, clear_requests, verdicts_checked);
		$display("Causes ok/id/dup/qci/arp/gbr: %0d/%0d/%0d/%0d/%0d/%0d, %0d not stored, ",
			cause_hits[0], cause_hits[1], cause_hits[2], cause_hits[3], cause_hits[4],
			cause_hits[5], unrecorded_filters,
			"peak lists %0d admitted and %0d failed.", peak_admitted, peak_rejected);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
